>>> src/bai_pkg.sv
// Shared package for the blob autotile index engine.
// Holds sizes, codes, control/status structs and the 256-to-47 mask lookup.
package bai_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int CELL_W    = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int TIDX_W    = 6;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int CMP_W     = 12;
  localparam int WIN       = 5;
  localparam int NCELL     = 9;
  localparam int STEP_W    = 3;
  localparam int NB_W      = 8;
  localparam int NMASK     = 47;
  localparam int GRID_RESET = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 1'b0,
    CFG_GRID_ROWS    = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_PLACE  = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef struct packed {
    logic              load;
    logic              rd_issue;
    logic [STEP_W-1:0] rd_off;
    logic              emit;
  } bai_cmd_t;

  typedef struct packed {
    logic pend_any;
    logic pend_last;
    logic out_free;
  } bai_sts_t;

  localparam logic [NB_W-1:0] BLOB_MASKS [NMASK] = '{
    8'd0,   8'd2,   8'd8,   8'd10,  8'd11,  8'd16,  8'd18,  8'd22,
    8'd24,  8'd26,  8'd27,  8'd30,  8'd31,  8'd64,  8'd66,  8'd72,
    8'd74,  8'd75,  8'd80,  8'd82,  8'd86,  8'd88,  8'd90,  8'd91,
    8'd94,  8'd95,  8'd104, 8'd106, 8'd107, 8'd120, 8'd122, 8'd123,
    8'd126, 8'd127, 8'd208, 8'd210, 8'd214, 8'd216, 8'd218, 8'd219,
    8'd222, 8'd223, 8'd248, 8'd250, 8'd251, 8'd254, 8'd255
  };

  // Map a gated 8-neighbor mask to its autotile index.
  function automatic logic [TIDX_W-1:0] blob_index(input logic [NB_W-1:0] mask);
    logic [TIDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NMASK; i++) begin
      if (BLOB_MASKS[i] == mask) idx = TIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> src/bai_in_if.sv
// Request channel of the blob autotile index engine.
// Depends on bai_pkg for field widths.
interface bai_in_if
  import bai_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CELL_W-1:0] cell_col;
  logic [CELL_W-1:0] cell_row;

  modport source (output valid, mode, cell_col, cell_row, input ready);
  modport sink   (input valid, mode, cell_col, cell_row, output ready);
endinterface

>>> src/bai_out_if.sv
// Result channel of the blob autotile index engine.
// Depends on bai_pkg for field widths.
interface bai_out_if
  import bai_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] out_col;
  logic [CELL_W-1:0] out_row;
  logic [TIDX_W-1:0] tile_index;
  logic              last;

  modport source (output valid, out_col, out_row, tile_index, last, input ready);
  modport sink   (input valid, out_col, out_row, tile_index, last, output ready);
endinterface

>>> src/blob_autotile_index_engine.sv
// Blob autotile index engine top level; uses bai_pkg, bai_in_if, bai_out_if, bai_ctrl, bai_dp.
// A request is accepted only while the engine is idle; its five row reads share the single
//   read port of the row memory, then its 0 to 9 results follow at one result per cycle
//   while the result channel is ready; a stalled result channel holds the results back.
// Reset: grid sizes go to 64 and all row valid bits clear at once; no clearing pass.
module blob_autotile_index_engine
  import bai_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  bai_in_if.sink               in_req,
  bai_out_if.source            out_res
);
  bai_cmd_t cmd;
  bai_sts_t sts;

  // Sequence each request: load, read rows, step results through the output register.
  bai_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the map, the window and the result register.
  bai_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_req.mode),
    .in_col    (in_req.cell_col),
    .in_row    (in_req.cell_row),
    .cmd       (cmd),
    .sts       (sts),
    .out_res   (out_res)
  );
endmodule

>>> src/bai_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> src/bai_dp.sv
// Datapath: config registers, row memory with row valid bits, 5x5 window,
// neighbor mask build, table lookup and the result register. Uses bai_pkg, bai_ram.
module bai_dp
  import bai_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_mode,
  input  logic [CELL_W-1:0]    in_col,
  input  logic [CELL_W-1:0]    in_row,
  input  bai_cmd_t             cmd,
  output bai_sts_t             sts,
  bai_out_if.source            out_res
);
  logic [CFG_W-1:0]    cols_r, rows_r;
  logic                mode_r;
  logic [CELL_W-1:0]   col_r, row_r;
  logic [MAX_ROWS-1:0] row_vld_r;
  logic                cap_vld_r, cap_rin_r, cap_rv_r;
  logic [STEP_W-1:0]   cap_idx_r;
  logic [WIN-1:0]      win_r [WIN];
  logic [NCELL-1:0]    done_r;
  logic                out_vld_r, last_r;
  logic [CELL_W-1:0]   out_col_r, out_row_r;
  logic [TIDX_W-1:0]   tidx_r;

  logic signed [CMP_W-1:0] eff_cols, eff_rows, rd_row, cc_col, cc_row;
  logic                rd_in, cell_in, wr_en;
  logic [ROW_AW-1:0]   raddr;
  logic [MAX_COLS-1:0] rdata, base_word, bit_mask, new_word;
  logic [WIN-1:0]      slice;
  logic [NCELL-1:0]    occ9, pend, sel_oh;
  logic [NB_W-1:0]     cell_mask [NCELL];
  logic [NB_W-1:0]     mask_sel;
  logic [1:0]          dc_sel, dr_sel;

  // Cap the configured sizes at the storage size.
  always_comb begin
    eff_cols = CMP_W'(cols_r);
    eff_rows = CMP_W'(rows_r);
    if (eff_cols > CMP_W'(MAX_COLS)) eff_cols = CMP_W'(MAX_COLS);
    if (eff_rows > CMP_W'(MAX_ROWS)) eff_rows = CMP_W'(MAX_ROWS);
  end

  // Row read for offset rd_off, rows row-2 .. row+2.
  always_comb begin
    rd_row = CMP_W'(row_r) + CMP_W'(cmd.rd_off) - CMP_W'(2);
    rd_in  = (rd_row >= 0) && (rd_row < eff_rows);
    raddr  = ROW_AW'(rd_row);
    cc_col = CMP_W'(col_r);
    cc_row = CMP_W'(row_r);
    cell_in = (cc_col < eff_cols) && (cc_row < eff_rows);
  end

  bai_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ROW_AW'(row_r)),
    .wdata (new_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Apply the edit to the center row as it returns, then cut a 5-bit slice.
  always_comb begin
    base_word = cap_rv_r ? rdata : '0;
    bit_mask  = MAX_COLS'(1) << COL_AW'(col_r);
    wr_en     = cap_vld_r && (cap_idx_r == STEP_W'(2)) && cell_in;
    new_word  = (mode_r == MODE_PLACE) ? (base_word | bit_mask) : (base_word & ~bit_mask);
    if (!wr_en) new_word = base_word;
    for (int j = 0; j < WIN; j++) begin
      logic signed [CMP_W-1:0] cc;
      cc = CMP_W'(col_r) + CMP_W'(j) - CMP_W'(2);
      slice[j] = cap_rin_r && (cc >= 0) && (cc < eff_cols) && new_word[COL_AW'(cc)];
    end
  end

  // Window cells in column-then-row order, masks with gated corners.
  always_comb begin
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        logic u, d, l, rt;
        u  = win_r[dr][dc+1];
        d  = win_r[dr+2][dc+1];
        l  = win_r[dr+1][dc];
        rt = win_r[dr+1][dc+2];
        occ9[dc*3+dr] = win_r[dr+1][dc+1];
        cell_mask[dc*3+dr] = {d & rt & win_r[dr+2][dc+2], d, d & l & win_r[dr+2][dc], rt, l,
                              u & rt & win_r[dr][dc+2], u, u & l & win_r[dr][dc]};
      end
    end
  end

  assign pend   = occ9 & ~done_r;
  assign sel_oh = pend & (~pend + NCELL'(1));

  always_comb begin
    mask_sel = '0;
    dc_sel   = '0;
    dr_sel   = '0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        if (sel_oh[dc*3+dr]) begin
          mask_sel = cell_mask[dc*3+dr];
          dc_sel   = 2'(dc);
          dr_sel   = 2'(dr);
        end
      end
    end
  end

  assign sts.pend_any  = |pend;
  assign sts.pend_last = ((pend & ~sel_oh) == '0);
  assign sts.out_free  = !out_vld_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= CFG_W'(GRID_RESET);
      rows_r    <= CFG_W'(GRID_RESET);
      row_vld_r <= '0;
      cap_vld_r <= 1'b0;
      done_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GRID_COLUMNS: cols_r <= cfg_wdata;
          CFG_GRID_ROWS:    rows_r <= cfg_wdata;
          default:          cols_r <= cols_r;
        endcase
      end
      if (wr_en) row_vld_r[ROW_AW'(row_r)] <= 1'b1;
      cap_vld_r <= cmd.rd_issue;
      if (cmd.load) done_r <= '0;
      else if (cmd.emit) done_r <= done_r | sel_oh;
      if (cmd.emit) out_vld_r <= 1'b1;
      else if (out_res.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      col_r  <= in_col;
      row_r  <= in_row;
    end
    if (cmd.rd_issue) begin
      cap_idx_r <= cmd.rd_off;
      cap_rin_r <= rd_in;
      cap_rv_r  <= row_vld_r[raddr];
    end
    if (cap_vld_r) win_r[cap_idx_r] <= slice;
    if (cmd.emit) begin
      out_col_r <= col_r + CELL_W'(dc_sel) - CELL_W'(1);
      out_row_r <= row_r + CELL_W'(dr_sel) - CELL_W'(1);
      tidx_r    <= blob_index(mask_sel);
      last_r    <= sts.pend_last;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.tile_index = tidx_r;
  assign out_res.last       = last_r;
endmodule

>>> src/bai_ctrl.sv
// Controller: accepts a request, sequences five row reads, then steps results out.
// Uses bai_pkg for the command and status structs.
module bai_ctrl
  import bai_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bai_sts_t sts,
  output bai_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.load     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.rd_off   = step_r;
    cmd.emit     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Issue rows until all five are out, then wait for the last data before moving to S_EMIT.
        if (step_r < STEP_W'(WIN)) begin
          cmd.rd_issue = 1'b1;
          step_nxt     = step_r + STEP_W'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.pend_any) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.pend_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end
endmodule
